// ===== hdl/atpts_pkg.sv =====
// Shared types, constants and helper functions for the ADC-driven PWM tone setter.
// No dependencies; the top level imports this package.
`default_nettype none

package atpts_pkg;

  localparam int unsigned DIV_W = 25;
  localparam int unsigned REM_W = 15;
  localparam int unsigned CNT_W = 5;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_TONE = 2'd2;

  localparam logic [6:0] TICKS_MODE1_LAST = 7'd99;
  localparam logic [6:0] TICKS_MODE2_LAST = 7'd9;

  localparam logic [14:0] FREQ_SPAN   = 15'd19980;
  localparam logic [14:0] FREQ_MIN    = 15'd20;
  localparam logic [14:0] ADC_FULL    = 15'd1023;
  localparam logic [14:0] DIGIT_BASE  = 15'd10;
  localparam logic [19:0] TIMER_CLOCK = 20'd1000000;

  localparam logic [CNT_W-1:0] STEPS_FREQ  = 5'd25;
  localparam logic [CNT_W-1:0] STEPS_TOP   = 5'd20;
  localparam logic [CNT_W-1:0] STEPS_SHOWN = 5'd15;
  localparam logic [CNT_W-1:0] STEPS_DIGIT = 5'd11;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_POST = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  typedef enum logic [5:0] {
    OP_FREQ  = 6'b000001,
    OP_TOP   = 6'b000010,
    OP_SHOWN = 6'b000100,
    OP_D0    = 6'b001000,
    OP_D1    = 6'b010000,
    OP_D2    = 6'b100000
  } op_t;

  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] code;
    unique case (digit)
      4'd0: code = 7'b0111111;
      4'd1: code = 7'b0000110;
      4'd2: code = 7'b1011011;
      4'd3: code = 7'b1001111;
      4'd4: code = 7'b1100110;
      4'd5: code = 7'b1101101;
      4'd6: code = 7'b1111101;
      4'd7: code = 7'b0000111;
      4'd8: code = 7'b1111111;
      4'd9: code = 7'b1100111;
      default: code = 7'b0000000;
    endcase
    return code;
  endfunction

  // Remainder by ten of a value below thirty-two, by two compare-and-subtract steps.
  function automatic logic [3:0] mod_ten(input logic [4:0] value);
    logic [4:0] v;
    v = value;
    if (v >= 5'd20) begin
      v = v - 5'd20;
    end
    if (v >= 5'd10) begin
      v = v - 5'd10;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/adc_to_pwm_tone_setter.sv =====
// Top level of the ADC-driven PWM tone setter with seven-segment readout.
// Depends on atpts_pkg for constants, state and operation types, and segment decoding.
//
// Usage:
// Each input request on in_valid/in_stall is one millisecond tick carrying adc_sample.
// Every accepted tick produces exactly one output request on out_valid/out_stall.
// The user must write the mode register via cfg_valid/cfg_ready/cfg_data while idle;
// the block does not enforce it. A tick that takes no new sample goes from idle
// straight to the emit step. A sampling tick runs a single shared restoring divider
// that yields one quotient bit per cycle: in mode 2 it forms the frequency, the PWM
// top, the shown value and its decimal digits one after another; in mode 1 it
// forms the decimal digits of the sample byte. in_stall stays high until the result
// is placed in the output register. A new tick is taken while that result still
// waits; if the receiver stalls, the next result waits in the sequencer and the
// input stays stalled. Synchronous reset clears the mode, the tick counter, the
// held PWM values and the output valid, and sets the held readout to zero.
`default_nettype none

module adc_to_pwm_tone_setter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [9:0]  adc_sample,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             active,
  output logic             updated,
  output logic [7:0]       pwm8_compare,
  output logic [15:0]      pwm_top,
  output logic [14:0]      pwm_half,
  output logic [6:0]       seg_ones,
  output logic [6:0]       seg_tens,
  output logic [6:0]       seg_hundreds,
  output logic [6:0]       seg_thousands
);
  import atpts_pkg::*;

  state_t state;
  op_t op;
  logic [1:0] mode;
  logic [6:0] tick_count;
  logic [7:0] compare_byte;
  logic [15:0] period_top;
  logic [14:0] half_period;
  logic [14:0] freq;
  logic [6:0] seg_ones_held;
  logic [6:0] seg_tens_held;
  logic [6:0] seg_hundreds_held;
  logic [6:0] seg_thousands_held;
  logic res_active;
  logic res_updated;

  logic [DIV_W-1:0] div_q;
  logic [REM_W-1:0] div_rem;
  logic [REM_W-1:0] div_divisor;
  logic [CNT_W-1:0] div_count;

  logic [REM_W:0] div_shifted;
  logic [REM_W+1:0] div_diff;
  logic div_ge;
  logic [DIV_W-1:0] product;
  logic [14:0] freq_calc;
  logic [15:0] top_quot;
  logic accept;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign div_shifted = {div_rem, div_q[DIV_W-1]};
  assign div_diff = {1'b0, div_shifted} - {2'b00, div_divisor};
  assign div_ge = !div_diff[REM_W+1];
  assign product = DIV_W'(FREQ_SPAN) * DIV_W'(adc_sample);
  assign freq_calc = div_q[14:0] + FREQ_MIN;
  assign top_quot = div_q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_D0;
      mode <= MODE_IDLE;
      tick_count <= '0;
      compare_byte <= '0;
      period_top <= '0;
      half_period <= '0;
      seg_ones_held <= seg_code(4'd0);
      seg_tens_held <= seg_code(4'd0);
      seg_hundreds_held <= seg_code(4'd0);
      seg_thousands_held <= seg_code(4'd0);
      res_active <= 1'b0;
      res_updated <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_active <= (mode == MODE_BYTE) || (mode == MODE_TONE);
            if (mode == MODE_BYTE && tick_count == TICKS_MODE1_LAST) begin
              tick_count <= '0;
              res_updated <= 1'b1;
              compare_byte <= adc_sample[9:2];
              div_q <= {3'b000, adc_sample[9:2], 14'b0};
              div_rem <= '0;
              div_divisor <= DIGIT_BASE;
              div_count <= STEPS_DIGIT;
              op <= OP_D0;
              state <= S_DIV;
            end else if (mode == MODE_TONE && tick_count == TICKS_MODE2_LAST) begin
              tick_count <= '0;
              res_updated <= 1'b1;
              div_q <= product;
              div_rem <= '0;
              div_divisor <= ADC_FULL;
              div_count <= STEPS_FREQ;
              op <= OP_FREQ;
              state <= S_DIV;
            end else begin
              if (mode == MODE_BYTE || mode == MODE_TONE) begin
                tick_count <= tick_count + 7'd1;
              end
              res_updated <= 1'b0;
              state <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          div_q <= {div_q[DIV_W-2:0], div_ge};
          div_rem <= div_ge ? div_diff[REM_W-1:0] : div_shifted[REM_W-1:0];
          div_count <= div_count - 5'd1;
          if (div_count == 5'd1) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          div_rem <= '0;
          unique case (op)
            OP_FREQ: begin
              freq <= freq_calc;
              div_q <= {TIMER_CLOCK, 5'b0};
              div_divisor <= freq_calc;
              div_count <= STEPS_TOP;
              op <= OP_TOP;
              state <= S_DIV;
            end
            OP_TOP: begin
              period_top <= top_quot - 16'd1;
              half_period <= top_quot[15:1];
              div_q <= {freq, 10'b0};
              div_divisor <= DIGIT_BASE;
              div_count <= STEPS_SHOWN;
              op <= OP_SHOWN;
              state <= S_DIV;
            end
            OP_SHOWN: begin
              div_q <= {div_q[10:0], 14'b0};
              div_count <= STEPS_DIGIT;
              op <= OP_D0;
              state <= S_DIV;
            end
            OP_D0: begin
              seg_ones_held <= seg_code(div_rem[3:0]);
              div_q <= {div_q[10:0], 14'b0};
              div_count <= STEPS_DIGIT;
              op <= OP_D1;
              state <= S_DIV;
            end
            OP_D1: begin
              seg_tens_held <= seg_code(div_rem[3:0]);
              div_q <= {div_q[10:0], 14'b0};
              div_count <= STEPS_DIGIT;
              op <= OP_D2;
              state <= S_DIV;
            end
            OP_D2: begin
              seg_hundreds_held <= seg_code(div_rem[3:0]);
              seg_thousands_held <= seg_code(mod_ten(div_q[4:0]));
              state <= S_EMIT;
            end
            default: begin
              state <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      active <= res_active;
      updated <= res_updated;
      pwm8_compare <= res_active ? compare_byte : '0;
      pwm_top <= res_active ? period_top : '0;
      pwm_half <= res_active ? half_period : '0;
      seg_ones <= res_active ? seg_ones_held : '0;
      seg_tens <= res_active ? seg_tens_held : '0;
      seg_hundreds <= res_active ? seg_hundreds_held : '0;
      seg_thousands <= res_active ? seg_thousands_held : '0;
    end
  end

  a_div_count_live: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_count != '0)
    else $error("divider running with an exhausted step count");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted tick did not start the sequencer");

  a_top_quot_range: assert property (@(posedge clk) disable iff (rst)
    state == S_POST && op == OP_TOP |-> div_q >= 25'd50 && div_q <= 25'd50000)
    else $error("PWM top quotient out of range");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("output request raised outside the emit step");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> !updated && pwm_top == '0 && seg_ones == '0)
    else $error("idle-mode result carries nonzero fields");

endmodule

`default_nettype wire
